[rtl/lcdns_pkg.sv]
package lcdns_pkg;

    // request kinds carried in s_axis_tuser
    typedef enum logic [2:0] {
        CMD_INIT       = 3'd0,
        CMD_COMMAND    = 3'd1,
        CMD_DATA       = 3'd2,
        CMD_SET_ADDR   = 3'd3,
        CMD_ROW_COLUMN = 3'd4
    } lcdns_cmd_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FUNCTION_SET  = 3'd0,
        REG_ENTRY_MODE    = 3'd1,
        REG_DISPLAY_CTRL  = 3'd2,
        REG_LINE_ONE      = 3'd3,
        REG_LINE_TWO      = 3'd4,
        REG_LINE_THREE    = 3'd5,
        REG_LINE_FOUR     = 3'd6
    } lcdns_reg_t;

    // register reset values
    localparam logic [7:0] FUNCTION_SET_RESET = 8'h28;
    localparam logic [7:0] ENTRY_MODE_RESET   = 8'h06;
    localparam logic [7:0] DISPLAY_CTRL_RESET = 8'h0E;
    localparam logic [6:0] LINE_ONE_RESET     = 7'h00;
    localparam logic [6:0] LINE_TWO_RESET     = 7'h40;
    localparam logic [6:0] LINE_THREE_RESET   = 7'h14;
    localparam logic [6:0] LINE_FOUR_RESET    = 7'h54;

    // instruction constants
    localparam logic [7:0] CLEAR_WORD      = 8'h01;
    localparam logic [7:0] SET_ADDR_FLAG   = 8'h80;
    localparam logic [7:0] SETTLE_LOW      = 8'h01;
    localparam logic [7:0] SETTLE_HIGH     = 8'h03;

    // init wake-up sequence
    localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
    localparam logic [1:0] WAIT_FIRST      = 2'd3;
    localparam logic [1:0] WAIT_REPEAT     = 2'd1;
    localparam logic [1:0] WAIT_NONE       = 2'd0;
    localparam logic [3:0] WAKE_LAST_STEP  = 4'd3;
    localparam logic [3:0] INIT_LAST_STEP  = 4'd11;

    // register-select levels
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // one queued job: a whole init run or a single byte
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] value;
    } lcdns_entry_t;

    // init words used by the back end
    typedef struct packed {
        logic [7:0] function_set;
        logic [7:0] entry_mode;
        logic [7:0] display_ctrl;
    } lcdns_init_words_t;

    // line base addresses used by the front end
    typedef struct packed {
        logic [6:0] line_one;
        logic [6:0] line_two;
        logic [6:0] line_three;
        logic [6:0] line_four;
    } lcdns_line_bases_t;

endpackage

[rtl/lcdns_front.sv]
module lcdns_front (
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,
    input  logic [2:0]                 s_axis_tuser,
    input  lcdns_pkg::lcdns_line_bases_t bases,
    input  logic                       queue_full,
    output logic                       push,
    output lcdns_pkg::lcdns_entry_t    push_entry
);
    import lcdns_pkg::*;

    logic [7:0] byte_value;
    logic [2:0] row;
    logic [5:0] column;
    logic [6:0] base;
    logic       row_ok;
    logic [6:0] address;
    logic       emits;

    assign byte_value = s_axis_tdata[7:0];
    assign row        = s_axis_tdata[10:8];
    assign column     = s_axis_tdata[16:11];

    assign s_axis_tready = !queue_full;

    // line base lookup for row positioning
    always_comb begin
        base   = bases.line_one;
        row_ok = 1'b1;
        case (row)
            3'd1: base = bases.line_one;
            3'd2: base = bases.line_two;
            3'd3: base = bases.line_three;
            3'd4: base = bases.line_four;
            default: row_ok = 1'b0;
        endcase
    end

    // address wraps within seven bits
    assign address = base + {1'b0, column} - 7'd1;

    // classify the request into one queue job, or none
    always_comb begin
        emits              = 1'b1;
        push_entry.is_init = 1'b0;
        push_entry.rs      = RS_INSTR;
        push_entry.value   = byte_value;
        case (lcdns_cmd_t'(s_axis_tuser))
            CMD_INIT: begin
                push_entry.is_init = 1'b1;
            end
            CMD_COMMAND: begin
                push_entry.value = byte_value;
            end
            CMD_DATA: begin
                push_entry.rs = RS_DATA;
            end
            CMD_SET_ADDR: begin
                push_entry.value = SET_ADDR_FLAG | {1'b0, byte_value[6:0]};
            end
            CMD_ROW_COLUMN: begin
                push_entry.value = SET_ADDR_FLAG | {1'b0, address};
                emits = row_ok && (column != 6'd0);
            end
            default: emits = 1'b0;
        endcase
    end

    assign push = s_axis_tvalid && s_axis_tready && emits;

endmodule

[rtl/lcdns_queue.sv]
module lcdns_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  lcdns_pkg::lcdns_entry_t push_entry,
    input  logic                    pop,
    output lcdns_pkg::lcdns_entry_t head,
    output logic                    empty,
    output logic                    full
);
    import lcdns_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    lcdns_entry_t  entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_COUNT);
    assign head  = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue read while empty");
`endif

endmodule

[rtl/lcdns_back.sv]
module lcdns_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lcdns_pkg::lcdns_entry_t      head,
    input  logic                         empty,
    output logic                         pop,
    input  lcdns_pkg::lcdns_init_words_t words,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,
    output logic [0:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import lcdns_pkg::*;

    logic [3:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic       rs_reg;
    logic [3:0] nibble_reg;
    logic [1:0] wait_reg;
    logic       settle_reg;
    logic       last_reg;

    logic       advance;
    logic       issue;
    logic [7:0] cur_byte;
    logic       low_half;
    logic       wake;
    logic [3:0] nibble;
    logic [1:0] wait_units;
    logic       settle;
    logic       last;

    // output register frees up when empty or taken
    assign advance = !valid_reg || m_axis_tready;
    assign issue   = advance && !empty;

    // byte for the current strobe
    always_comb begin
        cur_byte = head.value;
        if (head.is_init) begin
            case (step_reg[3:1])
                3'd2: cur_byte = words.function_set;
                3'd3: cur_byte = words.entry_mode;
                3'd4: cur_byte = words.display_ctrl;
                default: cur_byte = CLEAR_WORD;
            endcase
        end
    end

    // strobe fields
    always_comb begin
        wake       = head.is_init && (step_reg <= WAKE_LAST_STEP);
        low_half   = step_reg[0];
        nibble     = low_half ? cur_byte[3:0] : cur_byte[7:4];
        wait_units = WAIT_NONE;
        settle     = low_half && (head.rs == RS_INSTR)
                     && (cur_byte >= SETTLE_LOW) && (cur_byte <= SETTLE_HIGH);
        if (wake) begin
            settle = 1'b0;
            nibble = (step_reg == WAKE_LAST_STEP) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE;
            case (step_reg[1:0])
                2'd0: wait_units = WAIT_FIRST;
                2'd3: wait_units = WAIT_NONE;
                default: wait_units = WAIT_REPEAT;
            endcase
        end
        last = head.is_init ? (step_reg == INIT_LAST_STEP) : low_half;
    end

    assign pop = issue && last;

    // step counter and output valid
    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            valid_next = !empty;
        end
        if (issue) begin
            step_next = last ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // strobe payload register
    always_ff @(posedge aclk) begin
        if (issue) begin
            rs_reg     <= head.rs;
            nibble_reg <= nibble;
            wait_reg   <= wait_units;
            settle_reg <= settle;
            last_reg   <= last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, settle_reg, wait_reg, nibble_reg};
    assign m_axis_tuser  = rs_reg;
    assign m_axis_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    a_mid_run_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != 4'd0) |-> !empty)
        else $error("run in progress with no job at the queue head");
    a_byte_two_strobes: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg > 4'd1) |-> head.is_init)
        else $error("byte job past its second strobe");
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= INIT_LAST_STEP)
        else $error("step counter past end of init run");
    a_pop_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (step_reg == 4'd0))
        else $error("step counter not cleared after job finished");
`endif

endmodule

[rtl/char_lcd_nibble_sequencer_top.sv]
// path: a request is written into the job queue, and its first strobe is loaded from the
// queue head into the output register once that register is free, behind earlier strobes
// throughput: one strobe per cycle from the back end while a job is queued and the output
// is taken; a byte request gives two strobes, an init request twelve, and a request that
// sends nothing is not queued; the job queue (QUEUE_DEPTH entries) lets requests be taken
// while strobes drain; reset: synchronous active-low aresetn empties the queue and output
// register and returns all configuration registers to their documented values
module char_lcd_nibble_sequencer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // byte_value[7:0], row[10:8], column[16:11], zero pad
    input  logic [2:0]  s_axis_tuser,  // command[2:0]
    // strobe stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // nibble[3:0], wait_units[5:4], extra_settle[6], pad
    output logic [0:0]  m_axis_tuser,  // register_select[0]
    output logic        m_axis_tlast,  // last_of_run
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lcdns_pkg::*;

    logic [7:0] function_set_reg;
    logic [7:0] entry_mode_reg;
    logic [7:0] display_ctrl_reg;
    logic [6:0] line_one_reg;
    logic [6:0] line_two_reg;
    logic [6:0] line_three_reg;
    logic [6:0] line_four_reg;

    lcdns_line_bases_t bases;
    lcdns_init_words_t words;
    lcdns_entry_t      push_entry;
    lcdns_entry_t      head;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            function_set_reg <= FUNCTION_SET_RESET;
            entry_mode_reg   <= ENTRY_MODE_RESET;
            display_ctrl_reg <= DISPLAY_CTRL_RESET;
            line_one_reg     <= LINE_ONE_RESET;
            line_two_reg     <= LINE_TWO_RESET;
            line_three_reg   <= LINE_THREE_RESET;
            line_four_reg    <= LINE_FOUR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (lcdns_reg_t'(cfg_index))
                REG_FUNCTION_SET: function_set_reg <= cfg_data;
                REG_ENTRY_MODE:   entry_mode_reg   <= cfg_data;
                REG_DISPLAY_CTRL: display_ctrl_reg <= cfg_data;
                REG_LINE_ONE:     line_one_reg     <= cfg_data[6:0];
                REG_LINE_TWO:     line_two_reg     <= cfg_data[6:0];
                REG_LINE_THREE:   line_three_reg   <= cfg_data[6:0];
                REG_LINE_FOUR:    line_four_reg    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign bases.line_one   = line_one_reg;
    assign bases.line_two   = line_two_reg;
    assign bases.line_three = line_three_reg;
    assign bases.line_four  = line_four_reg;

    assign words.function_set = function_set_reg;
    assign words.entry_mode   = entry_mode_reg;
    assign words.display_ctrl = display_ctrl_reg;

    // request classification
    lcdns_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .bases         (bases),
        .queue_full    (full),
        .push          (push),
        .push_entry    (push_entry)
    );

    // job queue between front and back
    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    // strobe sequencing
    lcdns_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .words         (words),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
